// ===== rtl/tsq_pkg.sv =====
// Shared types and constants for the table-driven state sequencer.
package tsq_pkg;

    localparam int unsigned TABLE_ROWS_DEF  = 32;
    localparam int unsigned CONDITION_COUNT = 16;
    localparam logic [7:0]  HALT_STATE      = 8'd0;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_SET    = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [7:0]         row_from_state;
        logic [3:0]         row_condition;
        logic [7:0]         row_action;
        logic signed [15:0] row_argument;
        logic [7:0]         row_to_state;
        logic [7:0]         forced_state;
        logic [15:0]        condition_flags;
    } in_t;

    typedef struct packed {
        logic               fired;
        logic [7:0]         action_code;
        logic signed [15:0] action_argument;
        logic [7:0]         present_state;
        logic               status;
    } out_t;

    // One stored transition, 44 bits
    typedef struct packed {
        logic [7:0]         from_state;
        logic [3:0]         condition;
        logic [7:0]         action;
        logic signed [15:0] argument;
        logic [7:0]         to_state;
    } row_t;

    // Scan request: fire search or from-state existence check
    typedef struct packed {
        logic        fire_mode;
        logic [7:0]  key;
        logic [15:0] flags;
    } scan_req_t;

    typedef struct packed {
        logic done;
        logic hit;
        row_t row;
    } scan_res_t;

endpackage

// ===== rtl/tsq_row_ram.sv =====
// Transition row memory: one write port, one registered read port.
module tsq_row_ram #(
    parameter int unsigned DEPTH = tsq_pkg::TABLE_ROWS_DEF
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  tsq_pkg::row_t              wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output tsq_pkg::row_t              rd_data
);
    import tsq_pkg::*;

    row_t mem [DEPTH];
    row_t rd_data_reg;

    // Write appended rows
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one row a cycle for the scan
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tsq_scan.sv =====
// Row scan engine: walks stored rows one per cycle through a shared compare.
module tsq_scan #(
    parameter int unsigned TABLE_ROWS = tsq_pkg::TABLE_ROWS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  tsq_pkg::scan_req_t                  req,
    input  logic [$clog2(TABLE_ROWS+1)-1:0]     row_count,
    output logic                                rd_en,
    output logic [$clog2(TABLE_ROWS)-1:0]       rd_addr,
    input  tsq_pkg::row_t                       rd_data,
    output tsq_pkg::scan_res_t                  res
);
    import tsq_pkg::*;

    localparam int unsigned CntW = $clog2(TABLE_ROWS + 1);
    localparam int unsigned IdxW = $clog2(TABLE_ROWS);

    logic            busy_reg, busy_next;
    logic            pend_reg, pend_next;
    logic [CntW-1:0] idx_reg, idx_next;
    scan_req_t       req_reg, req_next;

    logic cond_ok;
    logic match;
    logic exhausted;
    logic done;

    // Shared compare against the row read last cycle
    always_comb begin
        cond_ok = (32'(rd_data.condition) < CONDITION_COUNT)
                  && req_reg.flags[rd_data.condition];
        match   = busy_reg && pend_reg && (rd_data.from_state == req_reg.key)
                  && (!req_reg.fire_mode || cond_ok);
    end

    assign exhausted = idx_reg >= row_count;
    assign done      = busy_reg && (match || exhausted);
    assign rd_en     = busy_reg && !match && !exhausted;
    assign rd_addr   = idx_reg[IdxW-1:0];

    // Advance the row index, stop on a hit or past the last row
    always_comb begin
        busy_next = busy_reg;
        pend_next = rd_en;
        idx_next  = idx_reg;
        req_next  = req_reg;
        if (rd_en) begin
            idx_next = idx_reg + CntW'(1);
        end
        if (done) begin
            busy_next = 1'b0;
        end
        if (start) begin
            busy_next = 1'b1;
            pend_next = 1'b0;
            idx_next  = '0;
            req_next  = req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
    end

    assign res.done = done;
    assign res.hit  = match;
    assign res.row  = rd_data;

    a_read_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (idx_reg < row_count))
        else $error("scan reads a row beyond the stored count");

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (!busy_reg || done))
        else $error("scan restarted while a scan is running");

    a_pending_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && !start) |=> pend_reg)
        else $error("issued row read not evaluated next cycle");

endmodule

// ===== rtl/table_driven_state_sequencer_top.sv =====
// Top level of the table-driven state sequencer: command control and result register.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    tsq_pkg::in_t  (cmd and row/state/flag fields)
//   m_        out        m_valid/m_ready    tsq_pkg::out_t (one result per command)
//
// Clear and append go from transfer through S_OUT to the result register.
// Set state runs one row scan; tick runs a fire scan and, on a hit, a check scan. Both
// use the row scan, which reads one stored row per cycle from the single RAM read port.
// Reset (aresetn low, synchronous) empties the table and puts the state at halt.
// s_ready is high only while idle; a finished result waits in the output register
// and the next command may be taken while it waits.
module table_driven_state_sequencer_top #(
    parameter int unsigned TABLE_ROWS = tsq_pkg::TABLE_ROWS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tsq_pkg::in_t   s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output tsq_pkg::out_t  m_payload
);
    import tsq_pkg::*;

    localparam int unsigned CntW = $clog2(TABLE_ROWS + 1);
    localparam int unsigned IdxW = $clog2(TABLE_ROWS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FIRE  = 4'b0010,
        S_CHECK = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [7:0]      cur_state_reg, cur_state_next;
    out_t            res_reg, res_next;
    logic            m_valid_reg, m_valid_next;
    out_t            m_payload_reg, m_payload_next;

    logic      s_accept;
    logic      table_full;
    logic      wr_en;
    row_t      wr_data;
    logic      scan_start;
    scan_req_t scan_req;
    scan_res_t scan_res;
    logic      rd_en;
    logic [IdxW-1:0] rd_addr;
    row_t      rd_data;

    assign s_ready    = (state_reg == S_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign table_full = (count_reg == CntW'(TABLE_ROWS));

    // Row built from the appended transfer
    always_comb begin
        wr_data.from_state = s_payload.row_from_state;
        wr_data.condition  = s_payload.row_condition;
        wr_data.action     = s_payload.row_action;
        wr_data.argument   = s_payload.row_argument;
        wr_data.to_state   = s_payload.row_to_state;
    end

    // Command sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_state_next = cur_state_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        wr_en          = 1'b0;
        scan_start     = 1'b0;
        scan_req       = '0;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    res_next               = '0;
                    res_next.present_state = cur_state_reg;
                    unique case (s_payload.cmd)
                        CMD_CLEAR: begin
                            count_next             = '0;
                            cur_state_next         = HALT_STATE;
                            res_next.present_state = HALT_STATE;
                            state_next             = S_OUT;
                        end
                        CMD_APPEND: begin
                            if (table_full) begin
                                res_next.status = 1'b1;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CntW'(1);
                            end
                            state_next = S_OUT;
                        end
                        CMD_SET: begin
                            scan_start         = 1'b1;
                            scan_req.fire_mode = 1'b0;
                            scan_req.key       = s_payload.forced_state;
                            state_next         = S_CHECK;
                        end
                        CMD_TICK: begin
                            if (cur_state_reg == HALT_STATE) begin
                                state_next = S_OUT;
                            end else begin
                                scan_start         = 1'b1;
                                scan_req.fire_mode = 1'b1;
                                scan_req.key       = cur_state_reg;
                                scan_req.flags     = s_payload.condition_flags;
                                state_next         = S_FIRE;
                            end
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_FIRE: begin
                if (scan_res.done) begin
                    if (scan_res.hit) begin
                        res_next.fired           = 1'b1;
                        res_next.action_code     = scan_res.row.action;
                        res_next.action_argument = scan_res.row.argument;
                        scan_start               = 1'b1;
                        scan_req.fire_mode       = 1'b0;
                        scan_req.key             = scan_res.row.to_state;
                        state_next               = S_CHECK;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_CHECK: begin
                // A hit means the key exists as a from-state; otherwise halt
                if (scan_res.done) begin
                    cur_state_next = scan_res.hit ? scan_res.row.from_state : HALT_STATE;
                    res_next.present_state = cur_state_next;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_state_reg <= HALT_STATE;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_state_reg <= cur_state_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg       <= res_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    tsq_row_ram #(
        .DEPTH (TABLE_ROWS)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IdxW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tsq_scan #(
        .TABLE_ROWS (TABLE_ROWS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (scan_start),
        .req       (scan_req),
        .row_count (count_reg),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res       (scan_res)
    );

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(TABLE_ROWS))
        else $error("row count exceeds table depth");

    a_full_append_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_payload.cmd == CMD_APPEND && table_full)
        |=> (count_reg == $past(count_reg)))
        else $error("refused append changed the row count");

    a_no_fire_when_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIRE) |-> (cur_state_reg != HALT_STATE))
        else $error("fire scan running in halt state");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the table-driven state sequencer top level.
module tb;
    import tsq_pkg::*;

    localparam int unsigned ROWS        = TABLE_ROWS_DEF;
    localparam int unsigned HALF_PERIOD = 6;
    localparam int unsigned TAIL_CYCLES = 2 * ROWS + 40;
    localparam int unsigned LIMIT_CYCLES = 600_000;
    localparam int unsigned RANDOM_ITEMS = 1000;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_payload;

    // Shadow copy of the sequencer: table, fill level, current state
    row_t        shadow_rows [ROWS];
    int unsigned shadow_count;
    logic [7:0]  shadow_state;

    out_t        pending_results[$];
    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned burst_left;
    bit          gaps_on;

    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  stall_phase   = '0;

    table_driven_state_sequencer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Return the state if some stored row starts from it, else halt
    function automatic logic [7:0] known_state(input logic [7:0] s);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_rows[i].from_state == s) return s;
        end
        return HALT_STATE;
    endfunction

    // Advance the shadow copy by one command and return the result it yields
    function automatic out_t next_result(input in_t item);
        out_t r;
        r = '0;
        case (item.cmd)
            CMD_CLEAR: begin
                shadow_count = 0;
                shadow_state = HALT_STATE;
            end
            CMD_APPEND: begin
                if (shadow_count >= ROWS) begin
                    r.status = 1'b1;
                end else begin
                    shadow_rows[shadow_count].from_state = item.row_from_state;
                    shadow_rows[shadow_count].condition  = item.row_condition;
                    shadow_rows[shadow_count].action     = item.row_action;
                    shadow_rows[shadow_count].argument   = item.row_argument;
                    shadow_rows[shadow_count].to_state   = item.row_to_state;
                    shadow_count++;
                end
            end
            CMD_SET: begin
                shadow_state = known_state(item.forced_state);
            end
            default: begin
                // First row in table order wins; ids past the flag vector never hold
                if (shadow_state != HALT_STATE) begin
                    for (int i = 0; i < shadow_count && !r.fired; i++) begin
                        if (shadow_rows[i].from_state == shadow_state &&
                            shadow_rows[i].condition < CONDITION_COUNT &&
                            item.condition_flags[shadow_rows[i].condition]) begin
                            r.fired           = 1'b1;
                            r.action_code     = shadow_rows[i].action;
                            r.action_argument = shadow_rows[i].argument;
                            shadow_state      = known_state(shadow_rows[i].to_state);
                        end
                    end
                end
            end
        endcase
        r.present_state = shadow_state;
        return r;
    endfunction

    // Build a command with every field random, to be narrowed by the caller
    function automatic in_t random_item(input cmd_t c);
        in_t it;
        it.cmd             = c;
        it.row_from_state  = 8'($urandom);
        it.row_condition   = 4'($urandom);
        it.row_action      = 8'($urandom);
        it.row_argument    = 16'($urandom);
        it.row_to_state    = 8'($urandom);
        it.forced_state    = 8'($urandom);
        it.condition_flags = 16'($urandom);
        return it;
    endfunction

    // Present one command in bursts, with random gaps when gaps are on; predict on transfer
    task automatic send_item(input in_t item);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(next_result(item));
        items_sent++;
    endtask

    task automatic clear_table();
        send_item(random_item(CMD_CLEAR));
    endtask

    task automatic append_row(input logic [7:0] from_s, input logic [3:0] cond,
                              input logic [7:0] act, input logic signed [15:0] arg,
                              input logic [7:0] to_s);
        in_t it;
        it = random_item(CMD_APPEND);
        it.row_from_state = from_s;
        it.row_condition  = cond;
        it.row_action     = act;
        it.row_argument   = arg;
        it.row_to_state   = to_s;
        send_item(it);
    endtask

    task automatic force_state(input logic [7:0] s);
        in_t it;
        it = random_item(CMD_SET);
        it.forced_state = s;
        send_item(it);
    endtask

    task automatic tick(input logic [15:0] flags);
        in_t it;
        it = random_item(CMD_TICK);
        it.condition_flags = flags;
        send_item(it);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Receiver: stall on a rotating 16-bit pattern that is swapped now and then
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1'b1;
        if (stall_phase == 4'hF && $urandom_range(0, 7) == 0) begin
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                         : 16'($urandom | 32'h1);
        end
        m_ready <= stall_pattern[stall_phase];
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: %p", m_payload);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_payload.fired !== want.fired) begin
                    $error("fired: expected %0d, got %0d", want.fired, m_payload.fired);
                    fail_count++;
                end
                if (m_payload.action_code !== want.action_code) begin
                    $error("action_code: expected %0d, got %0d",
                           want.action_code, m_payload.action_code);
                    fail_count++;
                end
                if (m_payload.action_argument !== want.action_argument) begin
                    $error("action_argument: expected %0d, got %0d",
                           want.action_argument, m_payload.action_argument);
                    fail_count++;
                end
                if (m_payload.present_state !== want.present_state) begin
                    $error("present_state: expected %0d, got %0d",
                           want.present_state, m_payload.present_state);
                    fail_count++;
                end
                if (m_payload.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_payload.status);
                    fail_count++;
                end
            end
        end
    end

    // Halted sequencer: ticks do nothing, sets on an empty table fall to halt
    task automatic test_after_reset();
        gaps_on = 1'b0;
        tick(16'hFFFF);
        force_state(8'hFF);
        force_state(HALT_STATE);
        append_row(HALT_STATE, 4'd0, 8'h11, 16'sd5, 8'h22);
        force_state(HALT_STATE);
        tick(16'hFFFF);
    endtask

    // Row order, field extremes, unknown targets, no match and clear
    task automatic test_firing();
        gaps_on = 1'b1;
        clear_table();
        append_row(8'h10, 4'd0,  8'h00, 16'sh7FFF, 8'h20);
        append_row(8'h10, 4'd15, 8'hFF, -16'sd32768, 8'hFF);
        append_row(8'h20, 4'd3,  8'hA5, -16'sd1, 8'h10);
        append_row(8'h20, 4'd7,  8'h5A, 16'sd1, 8'h99);
        append_row(8'hFF, 4'd15, 8'h3C, 16'sd0, 8'h10);
        force_state(8'h10);
        tick(16'h0000);
        tick(16'h8000);
        tick(16'h8000);
        tick(16'hFFFF);
        tick(16'h0080);
        tick(16'hFFFF);
        force_state(8'h20);
        tick(16'h0088);
        force_state(8'h77);
        clear_table();
        tick(16'hFFFF);
        force_state(8'h10);
    endtask

    // Fill the table, then refuse further appends
    task automatic test_table_full();
        logic [7:0] last_from;
        logic [3:0] last_cond;
        gaps_on = 1'b1;
        clear_table();
        for (int i = 0; i < ROWS; i++) begin
            last_from = 8'($urandom_range(1, 255));
            last_cond = 4'($urandom);
            append_row(last_from, last_cond, 8'($urandom), 16'($urandom), 8'($urandom));
        end
        append_row(8'($urandom), 4'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
        append_row(8'hFF, 4'hF, 8'hFF, -16'sd32768, 8'hFF);
        force_state(last_from);
        tick(16'h1 << last_cond);
        tick(16'hFFFF);
    endtask

    // Pick tick flags ranging from empty to dense
    function automatic logic [15:0] random_flags();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'h1 << $urandom_range(0, 15);
            2:       return 16'($urandom | $urandom);
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed programs on a small state pool, plus noise bursts
    task automatic test_random_programs();
        logic [7:0]  pool [5];
        int unsigned pool_size;
        int unsigned n_rows;
        int unsigned n_ticks;
        int unsigned start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8))
                    send_item(random_item(cmd_t'($urandom_range(0, 3))));
            end else begin
                pool_size = $urandom_range(1, 5);
                for (int i = 0; i < pool_size; i++) pool[i] = 8'($urandom);
                n_rows = ($urandom_range(0, 9) == 0) ? $urandom_range(20, ROWS + 3)
                                                     : $urandom_range(1, 10);
                clear_table();
                repeat (n_rows) begin
                    append_row(pool[$urandom_range(0, pool_size - 1)], 4'($urandom),
                               8'($urandom), 16'($urandom),
                               ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                   : pool[$urandom_range(0, pool_size - 1)]);
                end
                force_state(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                : pool[$urandom_range(0, pool_size - 1)]);
                n_ticks = $urandom_range(5, 20);
                repeat (n_ticks) begin
                    if ($urandom_range(0, 9) == 0)
                        force_state(pool[$urandom_range(0, pool_size - 1)]);
                    else
                        tick(random_flags());
                end
            end
        end
    endtask

    initial begin
        fail_count = 0;
        items_sent = 0;
        burst_left = 0;
        gaps_on    = 1'b0;
        shadow_count = 0;
        shadow_state = HALT_STATE;
        for (int i = 0; i < ROWS; i++) shadow_rows[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_after_reset();
        test_firing();
        test_table_full();
        test_random_programs();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("Some tests failed");
        $finish;
    end

endmodule
